/* src/srs_pkg.sv */
package srs_pkg;

  localparam int DEF_NUM_CHANNELS = 16;

  localparam int OP_W      = 2;
  localparam int CH_FIELD_W = 4;
  localparam int PULSE_W   = 12;
  localparam int DELAY_W   = 16;
  localparam int STEP_W    = 5;
  localparam int DIFF_W    = PULSE_W + 1;
  localparam int PROD_W    = PULSE_W + STEP_W;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [PULSE_W-1:0] RST_PULSE_HOME   = PULSE_W'(150);
  localparam logic [PULSE_W-1:0] RST_PULSE_THROWN = PULSE_W'(475);
  localparam logic [DELAY_W-1:0] RST_STEP_DELAY   = DELAY_W'(40);
  localparam logic [STEP_W-1:0]  RST_STEP_COUNT   = STEP_W'(25);

  localparam logic [1:0] REG_PULSE_HOME   = 2'd0;
  localparam logic [1:0] REG_PULSE_THROWN = 2'd1;
  localparam logic [1:0] REG_STEP_DELAY   = 2'd2;
  localparam logic [1:0] REG_STEP_COUNT   = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_home;
    logic [PULSE_W-1:0] pulse_thrown;
    logic [DELAY_W-1:0] step_delay;
    logic [STEP_W-1:0]  step_count;
  } cfg_t;

  typedef struct packed {
    logic toggle;
    logic move;
    logic ch_clear;
    logic ch_inc;
    logic scan;
    logic div_start;
    logic emit_step;
    logic emit_done;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic moving;
    logic fire;
    logic ch_last;
    logic div_busy;
    logic out_free;
    logic hold_valid;
    logic ramp_end;
  } dp_stat_t;

endpackage

/* src/srs_in_if.sv */
interface srs_in_if;
  logic                            valid;
  logic                            ready;
  logic [srs_pkg::OP_W-1:0]        operation;
  logic [srs_pkg::CH_FIELD_W-1:0]  channel;
  logic                            target_thrown;

  modport source (output valid, output operation, output channel, output target_thrown,
                  input ready);
  modport sink (input valid, input operation, input channel, input target_thrown,
                output ready);
endinterface

/* src/srs_out_if.sv */
interface srs_out_if;
  logic                            valid;
  logic                            ready;
  logic [srs_pkg::CH_FIELD_W-1:0]  out_channel;
  logic [srs_pkg::PULSE_W-1:0]     pulse;
  logic                            move_done;
  logic                            last;

  modport source (output valid, output out_channel, output pulse, output move_done,
                  output last, input ready);
  modport sink (input valid, input out_channel, input pulse, input move_done,
                input last, output ready);
endinterface

/* src/srs_div.sv */
module srs_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W:0]   rem_s;
  logic             ge;

  assign busy     = (cnt_r != '0);
  assign quotient = dvd_r;

  always_comb begin
    rem_s   = {rem_r, dvd_r[DVD_W-1]};
    ge      = (rem_s >= {1'b0, dvs_r});
    rem_nxt = ge ? DVS_W'(rem_s - {1'b0, dvs_r}) : rem_s[DVS_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule

/* src/srs_dp.sv */
module srs_dp #(
  parameter int NUM_CHANNELS = srs_pkg::DEF_NUM_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srs_pkg::dp_cmd_t               cmd,
  output srs_pkg::dp_stat_t              stat,
  input  srs_pkg::cfg_t                  cfg,
  input  logic [srs_pkg::CH_FIELD_W-1:0] in_channel,
  input  logic                           in_target_thrown,
  srs_out_if.source                      out_chan
);
  import srs_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic               moving_r   [NUM_CHANNELS];
  logic               at_thrown_r[NUM_CHANNELS];
  logic [PULSE_W-1:0] start_r    [NUM_CHANNELS];
  logic [PULSE_W-1:0] target_r   [NUM_CHANNELS];
  logic [STEP_W-1:0]  step_r     [NUM_CHANNELS];
  logic [DELAY_W-1:0] tick_r     [NUM_CHANNELS];

  logic [CH_W-1:0]    cur_r;
  logic [PULSE_W-1:0] from_r, to_r;
  logic [STEP_W-1:0]  k_r;

  logic               hold_valid_r, hold_done_r;
  logic [CH_W-1:0]    hold_ch_r;
  logic [PULSE_W-1:0] hold_pulse_r;

  logic               out_valid_r, out_done_r, out_last_r;
  logic [CH_W-1:0]    out_ch_r;
  logic [PULSE_W-1:0] out_pulse_r;

  logic [CH_W-1:0]          cmd_idx;
  logic                     cmd_ok;
  logic [PULSE_W-1:0]       cur_end, new_target;
  logic                     new_at_thrown;
  logic [DELAY_W-1:0]       delay_eff, tick_inc;
  logic [STEP_W-1:0]        steps_eff, k_inc;
  logic                     fire;
  logic signed [DIFF_W-1:0] diff;
  logic [PULSE_W-1:0]       mag, q12, step_pulse;
  logic [PROD_W-1:0]        prod, quo;
  logic                     push, move_out, emit;

  assign cmd_idx   = in_channel[CH_W-1:0];
  assign cmd_ok    = (cmd.toggle || cmd.move) && (32'(in_channel) < 32'(NUM_CHANNELS)) &&
                     !moving_r[cmd_idx];
  assign cur_end   = at_thrown_r[cmd_idx] ? cfg.pulse_thrown : cfg.pulse_home;

  always_comb begin
    if (cmd.toggle) begin
      new_target    = at_thrown_r[cmd_idx] ? cfg.pulse_home : cfg.pulse_thrown;
      new_at_thrown = !at_thrown_r[cmd_idx];
    end else begin
      new_target    = in_target_thrown ? cfg.pulse_thrown : cfg.pulse_home;
      new_at_thrown = in_target_thrown;
    end
  end

  assign delay_eff = (cfg.step_delay == '0) ? DELAY_W'(1) : cfg.step_delay;
  assign steps_eff = (cfg.step_count == '0) ? STEP_W'(1) : cfg.step_count;
  assign tick_inc  = tick_r[cur_r] + 1'b1;
  assign fire      = (tick_inc >= delay_eff);
  assign k_inc     = k_r + 1'b1;

  assign diff = $signed({1'b0, to_r}) - $signed({1'b0, from_r});
  assign mag  = diff[DIFF_W-1] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];
  assign prod = PROD_W'(mag) * PROD_W'(k_r);
  assign q12  = quo[PULSE_W-1:0];
  assign step_pulse = diff[DIFF_W-1] ? from_r - q12 : from_r + q12;

  srs_div #(
    .DVD_W(PROD_W),
    .DVS_W(STEP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (steps_eff),
    .busy     (stat.div_busy),
    .quotient (quo)
  );

  assign stat.moving     = moving_r[cur_r];
  assign stat.fire       = fire;
  assign stat.ch_last    = (cur_r == CH_W'(NUM_CHANNELS - 1));
  assign stat.out_free   = !hold_valid_r || !out_valid_r || out_chan.ready;
  assign stat.hold_valid = hold_valid_r;
  assign stat.ramp_end   = (k_inc >= steps_eff) || (k_inc == '0);

  assign emit     = cmd.emit_step || cmd.emit_done;
  assign push     = emit || cmd.flush;
  assign move_out = push && hold_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        moving_r[i]    <= 1'b0;
        at_thrown_r[i] <= 1'b0;
      end
    end else begin
      if (cmd_ok) begin
        moving_r[cmd_idx]    <= 1'b1;
        at_thrown_r[cmd_idx] <= new_at_thrown;
      end
      if (cmd.emit_done) begin
        moving_r[cur_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ok) begin
      start_r[cmd_idx]  <= cur_end;
      target_r[cmd_idx] <= new_target;
      step_r[cmd_idx]   <= '0;
      tick_r[cmd_idx]   <= '0;
    end
    if (cmd.scan) begin
      if (fire) begin
        tick_r[cur_r] <= '0;
        from_r        <= start_r[cur_r];
        to_r          <= target_r[cur_r];
        k_r           <= step_r[cur_r];
      end else begin
        tick_r[cur_r] <= tick_inc;
      end
    end
    if (cmd.emit_step) begin
      step_r[cur_r] <= k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.ch_clear) begin
        cur_r <= '0;
      end else if (cmd.ch_inc) begin
        cur_r <= cur_r + 1'b1;
      end
      if (emit) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid_r <= 1'b0;
      end
      if (move_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold_ch_r    <= cur_r;
      hold_pulse_r <= cmd.emit_done ? to_r : step_pulse;
      hold_done_r  <= cmd.emit_done;
    end
    if (move_out) begin
      out_ch_r    <= hold_ch_r;
      out_pulse_r <= hold_pulse_r;
      out_done_r  <= hold_done_r;
      out_last_r  <= cmd.flush;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_channel = CH_FIELD_W'(out_ch_r);
  assign out_chan.pulse       = out_pulse_r;
  assign out_chan.move_done   = out_done_r;
  assign out_chan.last        = out_last_r;
endmodule

/* src/srs_ctrl.sv */
module srs_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [srs_pkg::OP_W-1:0] in_operation,
  output logic                     in_ready,
  output srs_pkg::dp_cmd_t         cmd,
  input  srs_pkg::dp_stat_t        stat
);
  import srs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op;

  assign op = op_t'(in_operation);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op)
            OP_TICK: begin
              cmd.ch_clear = 1'b1;
              state_nxt    = ST_SCAN;
            end
            OP_TOGGLE: cmd.toggle = 1'b1;
            OP_MOVE:   cmd.move   = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = stat.moving;
        if (stat.moving && stat.fire) begin
          state_nxt = ST_MUL;
        end else begin
          cmd.ch_inc = !stat.ch_last;
          state_nxt  = stat.ch_last ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_step = 1'b1;
          if (stat.ramp_end) begin
            state_nxt = ST_DONE;
          end else begin
            cmd.ch_inc = !stat.ch_last;
            state_nxt  = stat.ch_last ? ST_FLUSH : ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.emit_done = 1'b1;
          cmd.ch_inc    = !stat.ch_last;
          state_nxt     = stat.ch_last ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (!stat.hold_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* src/servo_ramp_scheduler.sv */
// Channel   Direction  Handshake            Payload
// in_chan   sink       valid / ready        operation, channel, target_thrown
// out_chan  source     valid / ready        out_channel, pulse, move_done, last
// APB       slave      psel, penable, pready  paddr, pwdata, prdata
//
// A toggle or move command is taken in the idle state. A tick scans every channel in turn;
// a channel that takes a step passes through the multiply, divide and emit states, the
// divider giving one quotient bit per cycle, and finishing a ramp adds a done state.
// Reset is synchronous and active low; all channels come out of reset at home and at rest.
// A stalled result channel holds the walk at the next transaction to be passed on, while
// one result waits in the output register and one behind it.
module servo_ramp_scheduler #(
  parameter int NUM_CHANNELS = srs_pkg::DEF_NUM_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  srs_in_if.sink                     in_chan,
  srs_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [srs_pkg::ADDR_W-1:0] paddr,
  input  logic [srs_pkg::DATA_W-1:0] pwdata,
  output logic [srs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import srs_pkg::*;

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_home   <= RST_PULSE_HOME;
      cfg_r.pulse_thrown <= RST_PULSE_THROWN;
      cfg_r.step_delay   <= RST_STEP_DELAY;
      cfg_r.step_count   <= RST_STEP_COUNT;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_PULSE_HOME:   cfg_r.pulse_home   <= pwdata[PULSE_W-1:0];
        REG_PULSE_THROWN: cfg_r.pulse_thrown <= pwdata[PULSE_W-1:0];
        REG_STEP_DELAY:   cfg_r.step_delay   <= pwdata[DELAY_W-1:0];
        REG_STEP_COUNT:   cfg_r.step_count   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PULSE_HOME:   prdata = DATA_W'(cfg_r.pulse_home);
      REG_PULSE_THROWN: prdata = DATA_W'(cfg_r.pulse_thrown);
      REG_STEP_DELAY:   prdata = DATA_W'(cfg_r.step_delay);
      REG_STEP_COUNT:   prdata = DATA_W'(cfg_r.step_count);
      default:          prdata = '0;
    endcase
  end

  assign in_chan.ready = in_ready;

  srs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  srs_dp #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg              (cfg_r),
    .in_channel       (in_chan.channel),
    .in_target_thrown (in_chan.target_thrown),
    .out_chan         (out_chan)
  );
endmodule
